FILE: rtl/temp_scratchpad_checker_macros.svh
// Assertion macros shared by the scratchpad checker modules.
// No dependencies; included by modules that carry concurrent checks.
`ifndef TEMP_SCRATCHPAD_CHECKER_MACROS_SVH
`define TEMP_SCRATCHPAD_CHECKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TSC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scratchpad checker: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scratchpad checker: next-cycle check failed");

`endif

FILE: rtl/tsc_pkg.sv
// Types, constants and helper functions for the scratchpad checker.
// No dependencies; imported by every module of the block.
package tsc_pkg;

  localparam int unsigned ADDR_W = 3;

  // register word index (paddr[2])
  localparam logic REG_BAD_VALUE = 1'b0;

  localparam logic signed [15:0] BAD_VALUE_RESET = 16'sh8000;

  localparam logic [7:0] CFG_MASK  = 8'h1F;
  localparam logic [3:0] CFG_INDEX = 4'd4;
  localparam logic [3:0] CRC_INDEX = 4'd8;
  localparam logic [7:0] CRC_POLY  = 8'h8C;

  localparam logic [1:0] STATUS_GOOD     = 2'd0;
  localparam logic [1:0] STATUS_CFG_FAIL = 2'd1;
  localparam logic [1:0] STATUS_CRC_FAIL = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] temp_fixed;
    logic signed [7:0]  temp_rounded;
    logic [1:0]         status;
  } out_item_t;

  // Reflected CRC-8, one byte, LSB first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Whole degrees: upper byte plus the half-degree bit, 8-bit wrap.
  function automatic out_item_t make_result(input logic signed [15:0] fixed,
                                            input logic [1:0] status);
    out_item_t r;
    r.temp_fixed   = fixed;
    r.temp_rounded = fixed[15:8] + {7'd0, fixed[7]};
    r.status       = status;
    return r;
  endfunction

endpackage

FILE: rtl/tsc_frame.sv
// Frame tracker: byte position, running CRC-8, raw temperature capture.
// Depends on tsc_pkg and the assertion macro header.
`include "temp_scratchpad_checker_macros.svh"

module tsc_frame (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  tsc_pkg::in_item_t  item,
  input  logic signed [15:0] bad_value,
  output logic               res_valid,
  output tsc_pkg::out_item_t res_item
);
  import tsc_pkg::*;

  logic [3:0] byte_count, byte_count_next;
  logic [7:0] crc_value, crc_value_next;
  logic [7:0] low_byte, low_byte_next;
  logic [7:0] high_byte, high_byte_next;
  logic       frame_done, frame_done_next;

  logic [3:0]         idx;
  logic [7:0]         crc_base;
  logic               active;
  logic signed [15:0] good_fixed;

  always_comb begin
    idx             = item.frame_start ? 4'd0 : byte_count;
    crc_base        = item.frame_start ? 8'd0 : crc_value;
    active          = accept && (item.frame_start || !frame_done);
    good_fixed      = {high_byte[3:0], low_byte, 4'b0000};

    byte_count_next = byte_count;
    crc_value_next  = crc_value;
    low_byte_next   = low_byte;
    high_byte_next  = high_byte;
    frame_done_next = frame_done;
    res_valid       = 1'b0;
    res_item        = make_result(bad_value, STATUS_CRC_FAIL);

    if (active) begin
      byte_count_next = idx + 4'd1;
      crc_value_next  = crc_base;
      frame_done_next = 1'b0;
      if (idx == CRC_INDEX) begin
        frame_done_next = 1'b1;
        res_valid       = 1'b1;
        if (item.data_byte != crc_base) begin
          res_item = make_result(bad_value, STATUS_CRC_FAIL);
        end else begin
          res_item = make_result(good_fixed, STATUS_GOOD);
        end
      end else if (idx == CFG_INDEX && (item.data_byte & CFG_MASK) != CFG_MASK) begin
        frame_done_next = 1'b1;
        res_valid       = 1'b1;
        res_item        = make_result(bad_value, STATUS_CFG_FAIL);
      end else begin
        if (idx == 4'd0) begin
          low_byte_next = item.data_byte;
        end else if (idx == 4'd1) begin
          high_byte_next = item.data_byte;
        end
        crc_value_next = crc8_update(crc_base, item.data_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      crc_value  <= '0;
      low_byte   <= '0;
      high_byte  <= '0;
      frame_done <= 1'b1;
    end else begin
      byte_count <= byte_count_next;
      crc_value  <= crc_value_next;
      low_byte   <= low_byte_next;
      high_byte  <= high_byte_next;
      frame_done <= frame_done_next;
    end
  end

  // a result always closes the frame
  `TSC_ASSERT_NEXT(a_result_closes, clk, rst, res_valid, frame_done)
  // an open frame never runs past the CRC byte
  `TSC_ASSERT_SAME(a_count_bound, clk, rst, !frame_done, byte_count <= CRC_INDEX)
  // bytes outside a frame leave the tracker untouched
  `TSC_ASSERT_NEXT(a_idle_hold, clk, rst, frame_done && !(accept && item.frame_start),
                   frame_done && $stable(byte_count) && $stable(crc_value))

endmodule

FILE: rtl/tsc_outbuf.sv
// Result register with one skid entry; parts the input side from the output stall.
// Depends on tsc_pkg and the assertion macro header.
`include "temp_scratchpad_checker_macros.svh"

module tsc_outbuf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tsc_pkg::out_item_t push_item,
  output logic               full,
  output logic               result_valid,
  input  logic               result_stall,
  output tsc_pkg::out_item_t result_item
);
  import tsc_pkg::*;

  logic      out_valid;
  out_item_t out_item;
  logic      skid_valid;
  out_item_t skid_item;
  logic      take;

  assign take         = out_valid && !result_stall;
  assign full         = skid_valid;
  assign result_valid = out_valid;
  assign result_item  = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_item <= skid_item;
      end
    end else if (push) begin
      if (!out_valid || take) begin
        out_item <= push_item;
      end else begin
        skid_item <= push_item;
      end
    end
  end

  `TSC_ASSERT_SAME(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `TSC_ASSERT_NEXT(a_skid_drains, clk, rst, skid_valid && !result_stall,
                   out_valid && !skid_valid && result_item == $past(skid_item))
  `TSC_ASSERT_NEXT(a_overflow_to_skid, clk, rst,
                   push && !skid_valid && out_valid && result_stall, skid_valid)

endmodule

FILE: rtl/temp_scratchpad_checker.sv
// Scratchpad checker top level; uses tsc_pkg, tsc_frame and tsc_outbuf.
// A result is decided when byte 4 (configuration check failed) or byte 8 (CRC) is
// accepted and is registered in the result register, or in the skid entry while that is held.
// Throughput: one byte every cycle; byte_stall rises only while result register and skid are full.
// Reset (rst, synchronous, active high) closes any frame, clears the CRC and
// buffers, and loads bad_value with -32768.
module temp_scratchpad_checker (
  input  logic                     clk,
  input  logic                     rst,
  // byte channel
  input  logic                     byte_valid,
  output logic                     byte_stall,
  input  tsc_pkg::in_item_t        byte_item,
  // result channel
  output logic                     result_valid,
  input  logic                     result_stall,
  output tsc_pkg::out_item_t       result_item,
  // register port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [tsc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import tsc_pkg::*;

  logic signed [15:0] bad_value;
  logic               byte_accept;
  logic               res_valid;
  out_item_t          res_item;
  logic               buf_full;
  logic               reg_sel;

  // The only register sits at word 0; paddr[2] picks the word, low bits are byte lanes.
  assign reg_sel = (paddr[2] == REG_BAD_VALUE);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{16{bad_value[15]}}, bad_value} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bad_value <= BAD_VALUE_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      bad_value <= pwdata[15:0];
    end
  end

  // Stall comes from a register, so it never loops back onto byte_valid.
  assign byte_stall  = buf_full;
  assign byte_accept = byte_valid && !byte_stall;

  // Frame tracking, CRC and the result decision, all combinational in the cycle the byte is accepted.
  tsc_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .accept    (byte_accept),
    .item      (byte_item),
    .bad_value (bad_value),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  // Result register plus skid entry: one more result can be taken while the
  // previous result is held by result_stall; a full skid entry raises byte_stall.
  tsc_outbuf u_outbuf (
    .clk          (clk),
    .rst          (rst),
    .push         (res_valid),
    .push_item    (res_item),
    .full         (buf_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

FILE: test/tb.sv
// Self-checking testbench for temp_scratchpad_checker: directed scratchpad frames, then
// random frames under several bad_value settings. Depends on tsc_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb;
  import tsc_pkg::*;

  localparam int GAP_MAX        = 8;     // longest idle draw, either side
  localparam int PHASE_ITEMS    = 200;   // live bytes per random phase
  localparam int NUM_PHASES     = 6;
  localparam int SETTLE_CYCLES  = 4;     // pipeline drain before a register write
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all

  localparam logic [ADDR_W-1:0] BAD_VALUE_ADDR = {REG_BAD_VALUE, 2'b00};

  // Results that can be read straight off the frame: reset bad_value is -32768,
  // so its rounded form is -128; raw 0xFFFF shifts to 0xFFF0 and rounds up to 0.
  localparam out_item_t CFG_FAIL_AT_RESET = {16'h8000, 8'h80, STATUS_CFG_FAIL};
  localparam out_item_t CRC_FAIL_AT_RESET = {16'h8000, 8'h80, STATUS_CRC_FAIL};
  localparam out_item_t ALL_ONES_GOOD     = {16'hFFF0, 8'h00, STATUS_GOOD};
  localparam out_item_t NO_TEMP           = '0;

  // How the data byte of a row is formed when it is driven.
  typedef enum logic [1:0] {
    BYTE_AS_IS,    // literal byte
    BYTE_CRC_OK,   // running CRC of the open frame
    BYTE_CRC_BAD   // inverted running CRC, always a mismatch
  } byte_mode_t;

  typedef struct {
    in_item_t   item;
    byte_mode_t mode;
    bit         typed;   // want holds a hand-written result
    out_item_t  want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  in_item_t    byte_item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  out_item_t   result_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  temp_scratchpad_checker dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Scratchpad predictor: its own copy of the frame state and of bad_value.
  // ---------------------------------------------------------------------------
  logic [3:0]         frame_pos    = '0;   // index of the next byte in the frame
  logic [7:0]         crc_acc      = '0;   // CRC-8 over bytes 0..7 so far
  logic [7:0]         temp_lo      = '0;
  logic [7:0]         temp_hi      = '0;
  bit                 frame_closed = 1'b1; // idle until a frame_start byte
  logic signed [15:0] bad_val      = BAD_VALUE_RESET;

  out_item_t temps_due[$];   // expected results, oldest first
  stim_row_t stim_q[$];      // rows waiting to be driven
  int        live_items = 0; // bytes that the block does not ignore
  int        fails = 0;
  bit        no_idle = 1'b0; // both sides run flat out while set

  // Reflected CRC-8, polynomial 0x8C, LSB first.
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      fb = c[0];
      c  = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  // Whole degrees: upper byte plus the half-degree bit, wrapping in 8 bits.
  function automatic out_item_t temp_report(input logic [15:0] fx, input logic [1:0] st);
    out_item_t r;
    r.temp_fixed   = fx;
    r.temp_rounded = fx[15:8] + {7'd0, fx[7]};
    r.status       = st;
    return r;
  endfunction

  // Advances the frame state by one accepted byte; returns 1 when a result is due.
  function automatic bit scratchpad_step(input in_item_t it, output out_item_t res);
    logic [3:0]  idx;
    logic [15:0] raw;
    res = NO_TEMP;
    if (it.frame_start) begin
      // a start mark always opens a fresh frame, even mid-frame
      frame_pos    = '0;
      crc_acc      = '0;
      frame_closed = 1'b0;
    end else if (frame_closed) begin
      return 1'b0;             // stray byte, no frame open
    end
    idx       = frame_pos;
    frame_pos = frame_pos + 4'd1;
    if (idx == CRC_INDEX) begin
      frame_closed = 1'b1;
      raw = {temp_hi, temp_lo};
      if (it.data_byte != crc_acc) res = temp_report(bad_val, STATUS_CRC_FAIL);
      else                         res = temp_report(raw << 4, STATUS_GOOD);
      return 1'b1;
    end
    if (idx == CFG_INDEX && (it.data_byte & CFG_MASK) != CFG_MASK) begin
      // config byte check fails: report now, drop the rest of the frame
      frame_closed = 1'b1;
      res = temp_report(bad_val, STATUS_CFG_FAIL);
      return 1'b1;
    end
    if (idx == 4'd0)      temp_lo = it.data_byte;
    else if (idx == 4'd1) temp_hi = it.data_byte;
    crc_acc = crc8_next(crc_acc, it.data_byte);
    return 1'b0;
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  task automatic add_row(input logic [7:0] data, input bit fs, input byte_mode_t mode,
                         input bit typed, input out_item_t want);
    stim_row_t r;
    r.item.data_byte   = data;
    r.item.frame_start = fs;
    r.mode  = mode;
    r.typed = typed;
    r.want  = want;
    stim_q.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Byte channel driver. Entered on a clock edge; returns on the edge at which
  // the transaction is accepted, with valid still high so a zero gap stays
  // seamless.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input stim_row_t r);
    int        gap;
    in_item_t  it;
    out_item_t res;
    bit        hit;
    gap = draw_gap();
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // the predictor is current here, since every earlier byte is already taken
    it = r.item;
    if (r.mode == BYTE_CRC_OK)       it.data_byte = crc_acc;
    else if (r.mode == BYTE_CRC_BAD) it.data_byte = ~crc_acc;
    byte_valid <= 1'b1;
    byte_item  <= it;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    if (it.frame_start || !frame_closed) live_items++;
    hit = scratchpad_step(it, res);
    if (r.typed)  temps_due.push_back(r.want);
    else if (hit) temps_due.push_back(res);
  endtask

  task automatic drain_stim();
    while (stim_q.size() != 0) send_byte(stim_q.pop_front());
  endtask

  // Close the byte channel, let every expected result arrive, then let any
  // byte with no result clear the pipeline.
  task automatic settle();
    byte_valid <= 1'b0;
    while (temps_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write (setup + access), then read back.
  task automatic set_bad_value(input logic [15:0] v);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BAD_VALUE_ADDR;
    pwdata  <= {16'($urandom_range(0, 65535)), v};  // upper half is don't-care
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    bad_val = v;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[15:0] !== bad_val) begin
      $error("bad_value readback expected %0d got %0d", bad_val, $signed(rd[15:0]));
      fails++;
    end
  endtask

  // Random scratchpad traffic: mostly well-formed frames with random content,
  // some cut short by a new start, some stray bytes.
  task automatic gen_sequence();
    int         kind;
    int         n;
    int         pick;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    if (kind < 85) begin
      // full frame when kind < 70, else truncated after a random length
      n = (kind < 70) ? 8 : $urandom_range(0, 7);
      b = 8'($urandom_range(0, 255));
      add_row(b, 1'b1, BYTE_AS_IS, 1'b0, NO_TEMP);
      for (int i = 1; i <= n; i++) begin
        b = 8'($urandom_range(0, 255));
        // config byte usually passes so most frames reach the CRC byte
        if (i == CFG_INDEX && $urandom_range(0, 99) < 85) b = b | CFG_MASK;
        if (i == CRC_INDEX) begin
          pick = $urandom_range(0, 99);
          if (pick < 70)      add_row(b, 1'b0, BYTE_CRC_OK, 1'b0, NO_TEMP);
          else if (pick < 85) add_row(b, 1'b0, BYTE_CRC_BAD, 1'b0, NO_TEMP);
          else                add_row(b, 1'b0, BYTE_AS_IS, 1'b0, NO_TEMP);
        end else begin
          add_row(b, 1'b0, BYTE_AS_IS, 1'b0, NO_TEMP);
        end
      end
    end else begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        b = 8'($urandom_range(0, 255));
        add_row(b, ($urandom_range(0, 7) == 0), BYTE_AS_IS, 1'b0, NO_TEMP);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result channel: random stall, and the check of every accepted result
  // against the oldest expectation.
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    out_item_t w;
    if (!rst && result_valid && !result_stall) begin
      if (temps_due.size() == 0) begin
        $error("unexpected result: temp_fixed %0d temp_rounded %0d status %0d",
               result_item.temp_fixed, result_item.temp_rounded, result_item.status);
        fails++;
      end else begin
        w = temps_due.pop_front();
        if (result_item.temp_fixed !== w.temp_fixed) begin
          $error("temp_fixed expected %0d got %0d", w.temp_fixed, result_item.temp_fixed);
          fails++;
        end
        if (result_item.temp_rounded !== w.temp_rounded) begin
          $error("temp_rounded expected %0d got %0d",
                 w.temp_rounded, result_item.temp_rounded);
          fails++;
        end
        if (result_item.status !== w.status) begin
          $error("status expected %0d got %0d", w.status, result_item.status);
          fails++;
        end
      end
      stall_left = draw_gap();
    end else if (stall_left > 0) begin
      stall_left--;
    end
    result_stall <= (stall_left != 0);
  end

  // Watchdog: any transaction on any port resets the count.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((byte_valid && !byte_stall) || (result_valid && !result_stall) ||
        (psel && penable && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          target;
    logic [15:0] phase_bad;

    // Directed table, run with bad_value still at its reset value.
    add_row(8'hFF, 1'b0, BYTE_AS_IS, 1'b0, NO_TEMP);            // stray byte, ignored
    add_row(8'h50, 1'b1, BYTE_AS_IS, 1'b0, NO_TEMP);            // frame: config fail
    add_row(8'h05, 1'b0, BYTE_AS_IS, 1'b0, NO_TEMP);
    add_row(8'h4B, 1'b0, BYTE_AS_IS, 1'b0, NO_TEMP);
    add_row(8'h46, 1'b0, BYTE_AS_IS, 1'b0, NO_TEMP);
    add_row(8'hE0, 1'b0, BYTE_AS_IS, 1'b1, CFG_FAIL_AT_RESET);  // low five bits clear
    add_row(8'h7F, 1'b0, BYTE_AS_IS, 1'b0, NO_TEMP);            // after close, ignored
    add_row(8'hFF, 1'b1, BYTE_AS_IS, 1'b0, NO_TEMP);            // frame, abandoned
    add_row(8'hFF, 1'b0, BYTE_AS_IS, 1'b0, NO_TEMP);
    add_row(8'hFF, 1'b1, BYTE_AS_IS, 1'b0, NO_TEMP);            // restart mid-frame
    add_row(8'hFF, 1'b0, BYTE_AS_IS, 1'b0, NO_TEMP);            // raw 0xFFFF
    add_row(8'h00, 1'b0, BYTE_AS_IS, 1'b0, NO_TEMP);
    add_row(8'h80, 1'b0, BYTE_AS_IS, 1'b0, NO_TEMP);
    add_row(8'h1F, 1'b0, BYTE_AS_IS, 1'b0, NO_TEMP);            // exactly the mask
    add_row(8'hFF, 1'b0, BYTE_AS_IS, 1'b0, NO_TEMP);
    add_row(8'h00, 1'b0, BYTE_AS_IS, 1'b0, NO_TEMP);
    add_row(8'hFF, 1'b0, BYTE_AS_IS, 1'b0, NO_TEMP);
    add_row(8'h00, 1'b0, BYTE_CRC_OK, 1'b1, ALL_ONES_GOOD);     // both wraps
    add_row(8'h00, 1'b1, BYTE_AS_IS, 1'b0, NO_TEMP);            // frame: CRC mismatch
    add_row(8'h08, 1'b0, BYTE_AS_IS, 1'b0, NO_TEMP);            // raw 0x0800
    add_row(8'h55, 1'b0, BYTE_AS_IS, 1'b0, NO_TEMP);
    add_row(8'hAA, 1'b0, BYTE_AS_IS, 1'b0, NO_TEMP);
    add_row(8'hFF, 1'b0, BYTE_AS_IS, 1'b0, NO_TEMP);
    add_row(8'h01, 1'b0, BYTE_AS_IS, 1'b0, NO_TEMP);
    add_row(8'h10, 1'b0, BYTE_AS_IS, 1'b0, NO_TEMP);
    add_row(8'hFE, 1'b0, BYTE_AS_IS, 1'b0, NO_TEMP);
    add_row(8'h00, 1'b0, BYTE_CRC_BAD, 1'b1, CRC_FAIL_AT_RESET);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    drain_stim();

    // Random phases, each under its own bad_value; one phase with no idling.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (p)
        0:       phase_bad = 16'h7FFF;
        1:       phase_bad = 16'h0000;
        3:       phase_bad = 16'h8000;
        4:       phase_bad = 16'hFFFF;
        default: phase_bad = 16'($urandom_range(0, 65535));
      endcase
      set_bad_value(phase_bad);
      no_idle = (p == 2);
      target  = live_items + PHASE_ITEMS;
      while (live_items < target) begin
        gen_sequence();
        drain_stim();
      end
    end

    settle();
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
